// ===== src/dq_pkg.sv =====
// Shared types, constants and helpers for the double-ended queue.
// No dependencies; every other file of the block refers to it by scoped names.
package dq_pkg;

  // Storage geometry
  localparam int DEPTH = 32;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Field widths
  localparam int ACT_W = 3;
  localparam int VAL_W = 32;
  localparam int ST_W  = 2;
  localparam int OCC_W = 6;

  // Command queue between front and back
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PW    = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

  localparam logic [IDX_W-1:0] IDX_ONE  = IDX_W'(1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
  localparam logic [IDX_W:0]   WRAP_AT  = (IDX_W + 1)'(DEPTH);

  // Action codes on the input channel
  localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [ACT_W-1:0] ACT_PUSH_BACK  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_POP_BACK   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_LIST_FRONT = 3'd4;
  localparam logic [ACT_W-1:0] ACT_LIST_BACK  = 3'd5;
  localparam logic [ACT_W-1:0] ACT_COUNT      = 3'd6;

  // Status codes on the output channel
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT,
    OP_PUSH_BACK,
    OP_POP_FRONT,
    OP_POP_BACK,
    OP_LIST_FRONT,
    OP_LIST_BACK,
    OP_COUNT
  } op_e;

  typedef struct packed {
    op_e                     op;
    logic signed [VAL_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value_res;
    logic [ST_W-1:0]         status;
    logic [OCC_W-1:0]        occupancy;
    logic                    last;
  } res_t;

  // Ring index arithmetic: both operands are below DEPTH
  function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] a,
                                                input logic [IDX_W-1:0] b);
    logic [IDX_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= WRAP_AT) s = s - WRAP_AT;
    return s[IDX_W-1:0];
  endfunction

  function automatic logic [OCC_W-1:0] to_occ(input logic [CNT_W-1:0] c);
    return OCC_W'(c);
  endfunction

endpackage

// ===== src/dq_if.sv =====
// Valid/ready channel interfaces for the double-ended queue.
// Depends on dq_pkg for field widths.
interface dq_in_if;
  logic                             valid;
  logic                             ready;
  logic [dq_pkg::ACT_W-1:0]         action;
  logic signed [dq_pkg::VAL_W-1:0]  value;

  modport source (output valid, action, value, input ready);
  modport sink   (input valid, action, value, output ready);
endinterface

interface dq_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [dq_pkg::VAL_W-1:0]  value_res;
  logic [dq_pkg::ST_W-1:0]          status;
  logic [dq_pkg::OCC_W-1:0]         occupancy;
  logic                             last;

  modport source (output valid, value_res, status, occupancy, last, input ready);
  modport sink   (input valid, value_res, status, occupancy, last, output ready);
endinterface

// ===== src/dq_front.sv =====
// Front end: accepts input beats and decodes the action into a command.
// Depends on dq_pkg and dq_in_if.
module dq_front (
  dq_in_if.sink       in_i,
  output logic        cmd_valid_o,
  input  logic        cmd_ready_i,
  output dq_pkg::cmd_t cmd_o
);

  logic known;

  // Decode the action; the unused code is accepted and dropped
  always_comb begin
    known        = 1'b1;
    cmd_o.value  = in_i.value;
    cmd_o.op     = dq_pkg::OP_COUNT;
    case (in_i.action)
      dq_pkg::ACT_PUSH_FRONT: cmd_o.op = dq_pkg::OP_PUSH_FRONT;
      dq_pkg::ACT_PUSH_BACK:  cmd_o.op = dq_pkg::OP_PUSH_BACK;
      dq_pkg::ACT_POP_FRONT:  cmd_o.op = dq_pkg::OP_POP_FRONT;
      dq_pkg::ACT_POP_BACK:   cmd_o.op = dq_pkg::OP_POP_BACK;
      dq_pkg::ACT_LIST_FRONT: cmd_o.op = dq_pkg::OP_LIST_FRONT;
      dq_pkg::ACT_LIST_BACK:  cmd_o.op = dq_pkg::OP_LIST_BACK;
      dq_pkg::ACT_COUNT:      cmd_o.op = dq_pkg::OP_COUNT;
      default:                known    = 1'b0;
    endcase
  end

  assign cmd_valid_o = in_i.valid && known;
  assign in_i.ready  = cmd_ready_i;

endmodule

// ===== src/dq_cmd_fifo.sv =====
// Short command queue that decouples the front end from the back end.
// Depends on dq_pkg.
module dq_cmd_fifo (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         wr_valid_i,
  output logic         wr_ready_o,
  input  dq_pkg::cmd_t wr_data_i,
  output logic         rd_valid_o,
  input  logic         rd_ready_i,
  output dq_pkg::cmd_t rd_data_o
);

  dq_pkg::cmd_t                  ent_q [dq_pkg::CMDQ_DEPTH];
  logic [dq_pkg::CMDQ_PW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [dq_pkg::CMDQ_CW-1:0]    fill_q, fill_d;
  logic                          do_wr, do_rd;

  assign wr_ready_o = (fill_q != dq_pkg::CMDQ_CW'(dq_pkg::CMDQ_DEPTH));
  assign rd_valid_o = (fill_q != '0);
  assign rd_data_o  = ent_q[rptr_q];
  assign do_wr      = wr_valid_i && wr_ready_o;
  assign do_rd      = rd_valid_o && rd_ready_i;

  // Advance pointers and fill level
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    fill_d = fill_q;
    if (do_wr) begin
      wptr_d = (wptr_q == dq_pkg::CMDQ_PW'(dq_pkg::CMDQ_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_rd) begin
      rptr_d = (rptr_q == dq_pkg::CMDQ_PW'(dq_pkg::CMDQ_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      fill_d = fill_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      fill_q <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      fill_q <= fill_d;
    end
  end

  // Hold command payloads
  always_ff @(posedge clk_i) begin
    if (do_wr) ent_q[wptr_q] <= wr_data_i;
  end

endmodule

// ===== src/dq_back.sv =====
// Back end: ring store, pointers and result register of the double-ended queue.
// Depends on dq_pkg and dq_out_if.
module dq_back (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cmd_valid_i,
  output logic         cmd_ready_o,
  input  dq_pkg::cmd_t cmd_i,
  dq_out_if.source     out_o
);

  localparam logic [0:0] S_IDLE = 1'b0;
  localparam logic [0:0] S_READ = 1'b1;

  logic [0:0]                     state_q, state_d;
  logic [dq_pkg::IDX_W-1:0]       front_q, front_d;
  logic [dq_pkg::CNT_W-1:0]       cnt_q, cnt_d;
  logic [dq_pkg::CNT_W-1:0]       idx_q, idx_d;
  logic                           list_q, list_d;
  logic                           from_back_q, from_back_d;
  logic                           ov_q, ov_d;
  dq_pkg::res_t                   res_q, res_d;
  logic                           out_free, load, is_last;
  logic                           wr_en, rd_en;
  logic [dq_pkg::IDX_W-1:0]       wr_addr, rd_addr;
  logic [dq_pkg::CNT_W-1:0]       off;
  logic signed [dq_pkg::VAL_W-1:0] mem [dq_pkg::DEPTH];
  logic signed [dq_pkg::VAL_W-1:0] rd_data_q;

  assign out_free = !ov_q || out_o.ready;

  // Execute commands and sequence reads
  always_comb begin
    state_d     = state_q;
    front_d     = front_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    list_d      = list_q;
    from_back_d = from_back_q;
    cmd_ready_o = 1'b0;
    load        = 1'b0;
    res_d       = res_q;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    wr_addr     = front_q;
    rd_addr     = front_q;
    off         = '0;
    is_last     = 1'b1;
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i && out_free) begin
          cmd_ready_o = 1'b1;
          case (cmd_i.op)
            dq_pkg::OP_PUSH_FRONT, dq_pkg::OP_PUSH_BACK: begin
              load = 1'b1;
              if (cnt_q == dq_pkg::CNT_FULL) begin
                res_d = '{value_res: '0, status: dq_pkg::ST_FULL,
                          occupancy: dq_pkg::to_occ(cnt_q), last: 1'b1};
              end else begin
                wr_en = 1'b1;
                if (cmd_i.op == dq_pkg::OP_PUSH_FRONT) begin
                  front_d = dq_pkg::wrap_add(front_q, dq_pkg::IDX_LAST);
                  wr_addr = front_d;
                end else begin
                  off     = cnt_q;
                  wr_addr = dq_pkg::wrap_add(front_q, off[dq_pkg::IDX_W-1:0]);
                end
                cnt_d = cnt_q + 1'b1;
                res_d = '{value_res: cmd_i.value, status: dq_pkg::ST_OK,
                          occupancy: dq_pkg::to_occ(cnt_d), last: 1'b1};
              end
            end
            dq_pkg::OP_POP_FRONT, dq_pkg::OP_POP_BACK: begin
              if (cnt_q == '0) begin
                load  = 1'b1;
                res_d = '{value_res: '0, status: dq_pkg::ST_EMPTY,
                          occupancy: dq_pkg::to_occ(cnt_q), last: 1'b1};
              end else begin
                rd_en = 1'b1;
                if (cmd_i.op == dq_pkg::OP_POP_FRONT) begin
                  rd_addr = front_q;
                  front_d = dq_pkg::wrap_add(front_q, dq_pkg::IDX_ONE);
                end else begin
                  off     = cnt_q - 1'b1;
                  rd_addr = dq_pkg::wrap_add(front_q, off[dq_pkg::IDX_W-1:0]);
                end
                cnt_d   = cnt_q - 1'b1;
                list_d  = 1'b0;
                state_d = S_READ;
              end
            end
            dq_pkg::OP_LIST_FRONT, dq_pkg::OP_LIST_BACK: begin
              if (cnt_q == '0) begin
                load  = 1'b1;
                res_d = '{value_res: '0, status: dq_pkg::ST_EMPTY,
                          occupancy: dq_pkg::to_occ(cnt_q), last: 1'b1};
              end else begin
                rd_en       = 1'b1;
                from_back_d = (cmd_i.op == dq_pkg::OP_LIST_BACK);
                off         = from_back_d ? cnt_q - 1'b1 : '0;
                rd_addr     = dq_pkg::wrap_add(front_q, off[dq_pkg::IDX_W-1:0]);
                idx_d       = '0;
                list_d      = 1'b1;
                state_d     = S_READ;
              end
            end
            dq_pkg::OP_COUNT: begin
              load  = 1'b1;
              res_d = '{value_res: '0, status: dq_pkg::ST_OK,
                        occupancy: dq_pkg::to_occ(cnt_q), last: 1'b1};
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        if (out_free) begin
          load    = 1'b1;
          is_last = !list_q || (idx_q + 1'b1 == cnt_q);
          res_d   = '{value_res: rd_data_q, status: dq_pkg::ST_OK,
                      occupancy: dq_pkg::to_occ(cnt_q), last: is_last};
          if (is_last) begin
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_q + 1'b1;
            rd_en   = 1'b1;
            off     = from_back_q ? cnt_q - 1'b1 - idx_d : idx_d;
            rd_addr = dq_pkg::wrap_add(front_q, off[dq_pkg::IDX_W-1:0]);
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold a result until the sink takes it
  always_comb begin
    ov_d = ov_q;
    if (load) begin
      ov_d = 1'b1;
    end else if (out_o.ready) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      front_q     <= '0;
      cnt_q       <= '0;
      idx_q       <= '0;
      list_q      <= 1'b0;
      from_back_q <= 1'b0;
      ov_q        <= 1'b0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      list_q      <= list_d;
      from_back_q <= from_back_d;
      ov_q        <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) res_q <= res_d;
  end

  // Ring store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= cmd_i.value;
    if (rd_en) rd_data_q <= mem[rd_addr];
  end

  assign out_o.valid     = ov_q;
  assign out_o.value_res = res_q.value_res;
  assign out_o.status    = res_q.status;
  assign out_o.occupancy = res_q.occupancy;
  assign out_o.last      = res_q.last;

  // Occupancy never exceeds the store
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= dq_pkg::CNT_FULL)
    else $error("occupancy beyond depth");

  // Count only moves when a command is taken
  a_cnt_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_valid_i && cmd_ready_o) |=> $stable(cnt_q))
    else $error("count changed without a command");

  // A dropped push is only reported on a full store
  a_full_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && res_q.status == dq_pkg::ST_FULL) |-> res_q.occupancy == dq_pkg::to_occ(cnt_q)
      && cnt_q == dq_pkg::CNT_FULL)
    else $error("full status on a store with room");

  // An empty report carries zero occupancy
  a_empty_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && res_q.status == dq_pkg::ST_EMPTY) |-> res_q.occupancy == '0)
    else $error("empty status with elements stored");

endmodule

// ===== src/double_ended_queue.sv =====
// Top level of the double-ended queue: front decoder, command queue, back end.
// Depends on dq_pkg, dq_if, dq_front, dq_cmd_fifo and dq_back.
//
//   channel  dir  handshake        payload
//   in_i     in   valid / ready    action[2:0], value[31:0]
//   out_o    out  valid / ready    value_res[31:0], status[1:0], occupancy[5:0], last
//
// Push, count and any empty or full report load the result register straight from the idle state.
// Pop passes through the read state: the ring store read is registered.
// A listing of N elements yields one element per cycle while out_o is ready.
// The command queue buffers up to two commands, so input beats keep flowing while
// the back end works or the result register waits on the sink.
// Reset clears the pointers, the count, the command queue and the result valid flag;
// the store itself needs no clearing, since only written entries are read.
module double_ended_queue (
  input  logic     clk_i,
  input  logic     rst_ni,
  dq_in_if.sink    in_i,
  dq_out_if.source out_o
);

  logic         f_valid, f_ready, b_valid, b_ready;
  dq_pkg::cmd_t f_cmd, b_cmd;

  dq_front u_front (
    .in_i        (in_i),
    .cmd_valid_o (f_valid),
    .cmd_ready_i (f_ready),
    .cmd_o       (f_cmd)
  );

  dq_cmd_fifo u_cmd_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (f_valid),
    .wr_ready_o (f_ready),
    .wr_data_i  (f_cmd),
    .rd_valid_o (b_valid),
    .rd_ready_i (b_ready),
    .rd_data_o  (b_cmd)
  );

  dq_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (b_valid),
    .cmd_ready_o (b_ready),
    .cmd_i       (b_cmd),
    .out_o       (out_o)
  );

endmodule
